// ----- hw/rtl/bcdrtc_pkg.sv -----
// shared types and constants of the bcd calendar clock with alarms
// no dependencies; imported by bcdrtc_step and bcd_clock_set_and_alarm
package bcdrtc_pkg;

    // field widths
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned FLD_W     = 3;
    localparam int unsigned BCD_W     = 8;
    localparam int unsigned ALARM_W   = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned ON_CNT_W  = 10;

    // item commands
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd3;

    // time field codes
    localparam logic [FLD_W-1:0] FLD_SEC   = 3'd0;
    localparam logic [FLD_W-1:0] FLD_MIN   = 3'd1;
    localparam logic [FLD_W-1:0] FLD_HOUR  = 3'd2;
    localparam logic [FLD_W-1:0] FLD_DAY   = 3'd3;
    localparam logic [FLD_W-1:0] FLD_MONTH = 3'd4;
    localparam logic [FLD_W-1:0] FLD_YEAR  = 3'd5;
    localparam logic [FLD_W-1:0] FLD_CENT  = 3'd6;

    // register index of the first alarm
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM0 = 3'd0;

    // alarm value that never matches
    localparam logic [ALARM_W-1:0] ALARM_OFF = 16'hffff;

    // packed bcd calendar time
    typedef struct packed {
        logic [BCD_W-1:0] sec;
        logic [BCD_W-1:0] min;
        logic [BCD_W-1:0] hour;
        logic [BCD_W-1:0] day;
        logic [BCD_W-1:0] month;
        logic [BCD_W-1:0] year;
        logic [BCD_W-1:0] century;
    } t_time;

    // time after reset: 2000-01-01 00:00:00
    localparam t_time TIME_RESET = '{
        sec: 8'h00, min: 8'h00, hour: 8'h00, day: 8'h01,
        month: 8'h01, year: 8'h00, century: 8'h20
    };

    // one result item
    typedef struct packed {
        t_time tm;
        logic  relay;
        logic  hit;
    } t_result;

endpackage

// ----- hw/rtl/bcdrtc_step.sv -----
// next calendar time for one load or step item, bcd digit carry and field wraps
// depends on bcdrtc_pkg
module bcdrtc_step
    import bcdrtc_pkg::*;
(
    input  t_time            i_time,
    input  logic [CMD_W-1:0] i_command,
    input  logic [FLD_W-1:0] i_field,
    input  logic             i_down,
    input  logic [BCD_W-1:0] i_value,
    output t_time            o_time
);

    localparam logic [BCD_W-1:0] TEN_MASK = 8'h0a;
    localparam logic [BCD_W-1:0] NIB_LO   = 8'h0f;
    localparam logic [BCD_W-1:0] NIB_HI   = 8'hf0;
    localparam logic [BCD_W-1:0] CARRY    = 8'h10;
    localparam logic [BCD_W-1:0] NINE     = 8'h09;
    localparam logic [BCD_W-1:0] ONE      = 8'h01;
    localparam logic [BCD_W-1:0] SIXTY    = 8'h60;
    localparam logic [BCD_W-1:0] HOUR_END = 8'h24;
    localparam logic [BCD_W-1:0] MON_END  = 8'h13;
    localparam logic [BCD_W-1:0] MON_LAST = 8'h12;
    localparam logic [BCD_W-1:0] TOP99    = 8'h99;
    localparam logic [BCD_W-1:0] HUNDRED  = 8'd100;

    // add one, a low digit of 10, 11, 14 or 15 clears and carries
    function automatic logic [BCD_W-1:0] bcd_up(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] s;
        s = v + ONE;
        if ((s & TEN_MASK) == TEN_MASK) s = (s & NIB_HI) + CARRY;
        return s;
    endfunction

    // subtract one, a low digit of f becomes 9
    function automatic logic [BCD_W-1:0] bcd_down(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] s;
        s = v - ONE;
        if ((s & NIB_LO) == NIB_LO) s = (s & NIB_HI) + NINE;
        return s;
    endfunction

    function automatic logic [BCD_W-1:0] wrap100(input logic [BCD_W-1:0] v, input logic dn);
        logic [BCD_W-1:0] s;
        if (dn) s = (v == '0) ? TOP99 : bcd_down(v);
        else    s = (v == TOP99) ? '0 : bcd_up(v);
        return s;
    endfunction

    // digits as nibble values: hi*10 + lo, at most 165
    function automatic logic [BCD_W-1:0] nib_val(input logic [BCD_W-1:0] v);
        return {1'b0, v[7:4], 3'b000} + {3'b000, v[7:4], 1'b0} + {4'b0000, v[3:0]};
    endfunction

    function automatic logic [BCD_W-1:0] step60(input logic [BCD_W-1:0] v, input logic dn);
        logic [BCD_W-1:0] s;
        if (!dn) begin
            s = bcd_up(v);
            if (s == SIXTY) s = '0;
        end else begin
            s = (v == '0) ? SIXTY : v;
            s = bcd_down(s);
        end
        return s;
    endfunction

    // leap year on century*100+year; 100 is a multiple of 4, so the year
    // digits decide unless they make a whole hundred
    logic [BCD_W-1:0] w_yv;
    logic [BCD_W-1:0] w_cq;
    logic             w_hundred;
    logic             w_leap;
    logic [BCD_W-1:0] w_mdays;

    always_comb begin
        w_yv      = nib_val(i_time.year);
        w_hundred = (w_yv == '0) || (w_yv == HUNDRED);
        w_cq      = nib_val(i_time.century) + {7'b0, w_yv == HUNDRED};
        w_leap    = w_hundred ? (w_cq[1:0] == 2'b00) : (w_yv[1:0] == 2'b00);
    end

    // last day of the current month in bcd
    always_comb begin
        case (i_time.month) inside
            8'h04, 8'h06, 8'h09, 8'h11: w_mdays = 8'h30;
            8'h02:                      w_mdays = w_leap ? 8'h29 : 8'h28;
            default:                    w_mdays = 8'h31;
        endcase
    end

    // load or step one field
    always_comb begin
        o_time = i_time;
        if (i_command == CMD_LOAD) begin
            unique case (i_field)
                FLD_SEC:   o_time.sec     = i_value;
                FLD_MIN:   o_time.min     = i_value;
                FLD_HOUR:  o_time.hour    = i_value;
                FLD_DAY:   o_time.day     = i_value;
                FLD_MONTH: o_time.month   = i_value;
                FLD_YEAR:  o_time.year    = i_value;
                FLD_CENT:  o_time.century = i_value;
                default:   ;
            endcase
        end else if (i_command == CMD_STEP) begin
            unique case (i_field)
                FLD_SEC: o_time.sec = step60(i_time.sec, i_down);
                FLD_MIN: o_time.min = step60(i_time.min, i_down);
                FLD_HOUR: begin
                    if (!i_down) begin
                        o_time.hour = i_time.hour + ONE;
                        if (o_time.hour == HOUR_END) o_time.hour = '0;
                        if ((o_time.hour & TEN_MASK) == TEN_MASK)
                            o_time.hour = (o_time.hour & NIB_HI) + CARRY;
                    end else begin
                        o_time.hour = bcd_down((i_time.hour == '0) ? HOUR_END : i_time.hour);
                    end
                end
                FLD_DAY: begin
                    if (!i_down)
                        o_time.day = bcd_up((i_time.day == w_mdays) ? '0 : i_time.day);
                    else
                        o_time.day = bcd_down((i_time.day == ONE) ? w_mdays + ONE
                                                                  : i_time.day);
                end
                FLD_MONTH: begin
                    if (!i_down) begin
                        o_time.month = i_time.month + ONE;
                        if (o_time.month == MON_END) o_time.month = ONE;
                        if ((o_time.month & TEN_MASK) == TEN_MASK)
                            o_time.month = (o_time.month & NIB_HI) + CARRY;
                    end else begin
                        o_time.month = i_time.month - ONE;
                        if (o_time.month == '0) o_time.month = MON_LAST;
                        if ((o_time.month & NIB_LO) == NIB_LO)
                            o_time.month = (o_time.month & NIB_HI) + NINE;
                    end
                end
                FLD_YEAR: begin
                    // year wrap carries or borrows into the century
                    o_time.year = wrap100(i_time.year, i_down);
                    if ((!i_down && i_time.year == TOP99) || (i_down && i_time.year == '0))
                        o_time.century = wrap100(i_time.century, i_down);
                end
                FLD_CENT: o_time.century = wrap100(i_time.century, i_down);
                default:  ;
            endcase
        end
    end

endmodule

// ----- hw/rtl/bcd_clock_set_and_alarm.sv -----
// top level: bcd calendar clock with field set, hour:minute alarms and relay timer
// depends on bcdrtc_pkg and bcdrtc_step
//
// channel  direction  handshake                    payload
// in       input      i_in_valid / o_in_ready      i_command, i_field, i_down, i_value
// out      output     o_out_valid / i_out_ready    o_seconds .. o_century_now,
//                                                  o_relay_on, o_alarm_hit
// cfg      input      i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// one item per cycle while o_in_ready is high: the item updates the time,
// relay and on counter registers at the edge it is accepted, and its result is
// registered in the output or skid stage. results wait in a two-entry output
// register, so a new item is taken while one result is stalled; o_in_ready
// falls only when both are full. the cfg port is always ready.
// reset is synchronous, active low, and gives 2000-01-01 00:00:00, relay off.
module bcd_clock_set_and_alarm
    import bcdrtc_pkg::*;
#(
    parameter int unsigned ON_TICKS   = 1000,
    parameter int unsigned NUM_ALARMS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item input
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [FLD_W-1:0]     i_field,
    input  logic                 i_down,
    input  logic [BCD_W-1:0]     i_value,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BCD_W-1:0]     o_seconds,
    output logic [BCD_W-1:0]     o_minutes,
    output logic [BCD_W-1:0]     o_hours,
    output logic [BCD_W-1:0]     o_day_of_month,
    output logic [BCD_W-1:0]     o_month_now,
    output logic [BCD_W-1:0]     o_year_low,
    output logic [BCD_W-1:0]     o_century_now,
    output logic                 o_relay_on,
    output logic                 o_alarm_hit,
    // alarm register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ALARM_W-1:0]   i_cfg_data
);

    localparam logic [ON_CNT_W-1:0] ON_END = ON_CNT_W'(ON_TICKS);

    t_time               r_time;
    t_time               n_time;
    logic                r_relay;
    logic                n_relay;
    logic [ON_CNT_W-1:0] r_on_count;
    logic [ON_CNT_W-1:0] n_on_count;
    logic [ALARM_W-1:0]  r_alarm [NUM_ALARMS];
    logic                w_match;
    logic                w_hit;
    logic                w_accept;
    logic                w_pop;
    t_result             w_res;
    t_result             r_out;
    logic                r_out_valid;
    t_result             r_skid;
    logic                r_skid_valid;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_pop       = r_out_valid && i_out_ready;
    assign o_in_ready  = !r_skid_valid;
    assign o_cfg_ready = 1'b1;

    // alarm registers
    for (genvar g = 0; g < NUM_ALARMS; g++) begin : g_alarm
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_alarm[g] <= ALARM_OFF;
            end else if (i_cfg_valid && i_cfg_index == CFG_ALARM0 + CFG_IDX_W'(g)) begin
                r_alarm[g] <= i_cfg_data;
            end
        end
    end

    // load and step of the time fields
    bcdrtc_step u_step (
        .i_time    (r_time),
        .i_command (i_command),
        .i_field   (i_field),
        .i_down    (i_down),
        .i_value   (i_value),
        .o_time    (n_time)
    );

    // compare every alarm against the current hour and minute
    always_comb begin
        w_match = 1'b0;
        for (int i = 0; i < NUM_ALARMS; i++) begin
            if (r_alarm[i] != ALARM_OFF && r_alarm[i][15:8] == r_time.hour
                && r_alarm[i][7:0] == r_time.min)
                w_match = 1'b1;
        end
    end

    // relay and on counter
    always_comb begin
        w_hit      = 1'b0;
        n_relay    = r_relay;
        n_on_count = r_on_count;
        if (i_command == CMD_CHECK) begin
            w_hit = (r_time.sec == '0) && w_match;
            if (w_hit) begin
                n_relay    = 1'b1;
                n_on_count = '0;
            end
        end else if (i_command == CMD_TICK && r_on_count < ON_END) begin
            n_on_count = r_on_count + 1'b1;
            if (n_on_count == ON_END) n_relay = 1'b0;
        end
    end

    assign w_res = '{tm: n_time, relay: n_relay, hit: w_hit};

    // state update on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time     <= TIME_RESET;
            r_relay    <= 1'b0;
            r_on_count <= ON_END;
        end else if (w_accept) begin
            r_time     <= n_time;
            r_relay    <= n_relay;
            r_on_count <= n_on_count;
        end
    end

    // output stage and skid stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) r_skid_valid <= 1'b0;
        end else if (w_pop || !r_out_valid) begin
            r_out_valid <= w_accept;
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // output stage and skid stage payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) r_out <= r_skid;
        end else if (w_pop || !r_out_valid) begin
            r_out <= w_res;
        end else begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_seconds      = r_out.tm.sec;
    assign o_minutes      = r_out.tm.min;
    assign o_hours        = r_out.tm.hour;
    assign o_day_of_month = r_out.tm.day;
    assign o_month_now    = r_out.tm.month;
    assign o_year_low     = r_out.tm.year;
    assign o_century_now  = r_out.tm.century;
    assign o_relay_on     = r_out.relay;
    assign o_alarm_hit    = r_out.hit;

`ifndef SYNTHESIS
    // skid stage only fills behind a full output stage
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds an item while output stage is empty");

    // relay is on exactly while the on counter runs
    a_relay_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_relay == (r_on_count < ON_END))
        else $error("relay state disagrees with on counter");

    // on counter never passes its end value
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_on_count <= ON_END)
        else $error("on counter beyond end value");

    // an accepted alarm hit energizes the relay
    a_hit_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_hit) |=> (r_relay && r_on_count == '0))
        else $error("alarm hit did not start the relay");

    // a result that reports a hit also reports the relay on
    a_out_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_alarm_hit) |-> o_relay_on)
        else $error("hit result shows relay off");
`endif

endmodule

// ----- verif/bcd_clock_set_and_alarm_checker.sv -----
// result checker for the bcd calendar clock: mirrors the clock, alarms and relay timer
// depends on bcdrtc_pkg; instantiated beside the block by bcd_clock_set_and_alarm_tb
`timescale 1ns / 1ps

module bcd_clock_set_and_alarm_checker
    import bcdrtc_pkg::*;
#(
    parameter int unsigned ON_TICKS   = 1000,
    parameter int unsigned NUM_ALARMS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item input channel
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [FLD_W-1:0]     i_field,
    input  logic                 i_down,
    input  logic [BCD_W-1:0]     i_value,
    // result channel
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [BCD_W-1:0]     i_seconds,
    input  logic [BCD_W-1:0]     i_minutes,
    input  logic [BCD_W-1:0]     i_hours,
    input  logic [BCD_W-1:0]     i_day_of_month,
    input  logic [BCD_W-1:0]     i_month_now,
    input  logic [BCD_W-1:0]     i_year_low,
    input  logic [BCD_W-1:0]     i_century_now,
    input  logic                 i_relay_on,
    input  logic                 i_alarm_hit,
    // alarm register writes
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ALARM_W-1:0]   i_cfg_data,
    // to the testbench top
    output int unsigned          o_err_count,
    output int unsigned          o_pending
);

    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned ALARM_REGS  = 8;

    // mirrored block state
    t_time                time_now;
    logic                 relay_now;
    logic [ON_CNT_W-1:0]  on_cnt;
    logic [ALARM_W-1:0]   alarm_tab [ALARM_REGS];

    // readouts still owed by the block, oldest first
    t_result              due_results [$];

    // bcd increment with low digit carry
    function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        r = v + 8'h01;
        if ((r & 8'h0a) == 8'h0a) r = (r & 8'hf0) + 8'h10;
        return r;
    endfunction

    // bcd decrement with low digit borrow
    function automatic logic [BCD_W-1:0] bcd_dec(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        r = v - 8'h01;
        if ((r & 8'h0f) == 8'h0f) r = (r & 8'hf0) + 8'h09;
        return r;
    endfunction

    function automatic logic [BCD_W-1:0] cent_up(input logic [BCD_W-1:0] v);
        return (v == 8'h99) ? 8'h00 : bcd_inc(v);
    endfunction

    function automatic logic [BCD_W-1:0] cent_down(input logic [BCD_W-1:0] v);
        return (v == 8'h00) ? 8'h99 : bcd_dec(v);
    endfunction

    // last day of the held month, gregorian leap rule on nibble digits
    function automatic logic [BCD_W-1:0] last_day(input t_time t);
        int unsigned yr;
        bit          leap;
        if (t.month == 8'h04 || t.month == 8'h06 || t.month == 8'h09 || t.month == 8'h11)
            return 8'h30;
        if (t.month != 8'h02)
            return 8'h31;
        yr = (t.century[7:4] * 10 + t.century[3:0]) * 100 + t.year[7:4] * 10 + t.year[3:0];
        leap = ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
        return leap ? 8'h29 : 8'h28;
    endfunction

    // one field stepped up or down with its own wrap
    function automatic t_time step_field(input t_time t, input logic [FLD_W-1:0] fld,
                                         input logic dn);
        t_time            n;
        logic [BCD_W-1:0] v;
        n = t;
        case (fld)
            FLD_SEC, FLD_MIN: begin
                v = (fld == FLD_SEC) ? n.sec : n.min;
                if (!dn) begin
                    v = bcd_inc(v);
                    if (v == 8'h60) v = 8'h00;
                end else begin
                    if (v == 8'h00) v = 8'h60;
                    v = bcd_dec(v);
                end
                if (fld == FLD_SEC) n.sec = v;
                else n.min = v;
            end
            FLD_HOUR: begin
                if (!dn) begin
                    v = n.hour + 8'h01;
                    if (v == 8'h24) v = 8'h00;
                    if ((v & 8'h0a) == 8'h0a) v = (v & 8'hf0) + 8'h10;
                    n.hour = v;
                end else begin
                    v = n.hour;
                    if (v == 8'h00) v = 8'h24;
                    n.hour = bcd_dec(v);
                end
            end
            FLD_DAY: begin
                v = n.day;
                if (!dn) begin
                    if (v == last_day(n)) v = 8'h00;
                    n.day = bcd_inc(v);
                end else begin
                    if (v == 8'h01) v = last_day(n) + 8'h01;
                    n.day = bcd_dec(v);
                end
            end
            FLD_MONTH: begin
                if (!dn) begin
                    v = n.month + 8'h01;
                    if (v == 8'h13) v = 8'h01;
                    if ((v & 8'h0a) == 8'h0a) v = (v & 8'hf0) + 8'h10;
                end else begin
                    v = n.month - 8'h01;
                    if (v == 8'h00) v = 8'h12;
                    if ((v & 8'h0f) == 8'h0f) v = (v & 8'hf0) + 8'h09;
                end
                n.month = v;
            end
            FLD_YEAR: begin
                if (!dn) begin
                    if (n.year == 8'h99) begin
                        n.year    = 8'h00;
                        n.century = cent_up(n.century);
                    end else begin
                        n.year = bcd_inc(n.year);
                    end
                end else begin
                    if (n.year == 8'h00) begin
                        n.year    = 8'h99;
                        n.century = cent_down(n.century);
                    end else begin
                        n.year = bcd_dec(n.year);
                    end
                end
            end
            FLD_CENT: n.century = dn ? cent_down(n.century) : cent_up(n.century);
            default: ;
        endcase
        return n;
    endfunction

    // applies one item to the mirrored state and returns the readout it causes
    function automatic t_result apply_item(input logic [CMD_W-1:0] cmd,
                                           input logic [FLD_W-1:0] fld, input logic dn,
                                           input logic [BCD_W-1:0] val);
        t_result r;
        logic    hit;
        hit = 1'b0;
        case (cmd)
            CMD_LOAD: begin
                case (fld)
                    FLD_SEC:   time_now.sec     = val;
                    FLD_MIN:   time_now.min     = val;
                    FLD_HOUR:  time_now.hour    = val;
                    FLD_DAY:   time_now.day     = val;
                    FLD_MONTH: time_now.month   = val;
                    FLD_YEAR:  time_now.year    = val;
                    FLD_CENT:  time_now.century = val;
                    default: ;
                endcase
            end
            CMD_STEP: time_now = step_field(time_now, fld, dn);
            CMD_CHECK: begin
                // alarms only fire at second zero
                if (time_now.sec == 8'h00) begin
                    for (int i = 0; i < NUM_ALARMS && i < ALARM_REGS; i++) begin
                        if (alarm_tab[i] != ALARM_OFF && alarm_tab[i][15:8] == time_now.hour
                            && alarm_tab[i][7:0] == time_now.min)
                            hit = 1'b1;
                    end
                    if (hit) begin
                        relay_now = 1'b1;
                        on_cnt    = '0;
                    end
                end
            end
            CMD_TICK: begin
                // relay timer, idle once it has reached the on time
                if (on_cnt < ON_TICKS) begin
                    on_cnt = on_cnt + 1'b1;
                    if (on_cnt == ON_TICKS) relay_now = 1'b0;
                end
            end
            default: ;
        endcase
        r.tm    = time_now;
        r.relay = relay_now;
        r.hit   = hit;
        return r;
    endfunction

    // watch the three channels at each rising edge
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            time_now  = TIME_RESET;
            relay_now = 1'b0;
            on_cnt    = ON_CNT_W'(ON_TICKS);
            for (int i = 0; i < ALARM_REGS; i++) alarm_tab[i] = ALARM_OFF;
            due_results.delete();
        end else begin
            // compare the readout taken now with the oldest one owed
            if (i_out_valid && i_out_ready) begin
                got = {i_seconds, i_minutes, i_hours, i_day_of_month, i_month_now,
                       i_year_low, i_century_now, i_relay_on, i_alarm_hit};
                if (due_results.size() == 0) begin
                    o_err_count++;
                    if (o_err_count <= MAX_REPORTS)
                        $display("%0t: result item with none pending: %h", $realtime, got);
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) begin
                        o_err_count++;
                        if (o_err_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch  sec min hour day mon yr cent relay hit",
                                     $realtime);
                            $display("  expected  %h  %h  %h   %h  %h  %h %h   %b     %b",
                                     want.tm.sec, want.tm.min, want.tm.hour, want.tm.day,
                                     want.tm.month, want.tm.year, want.tm.century,
                                     want.relay, want.hit);
                            $display("  actual    %h  %h  %h   %h  %h  %h %h   %b     %b",
                                     got.tm.sec, got.tm.min, got.tm.hour, got.tm.day,
                                     got.tm.month, got.tm.year, got.tm.century,
                                     got.relay, got.hit);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                alarm_tab[i_cfg_index] = i_cfg_data;
            if (i_in_valid && i_in_ready)
                due_results.push_back(apply_item(i_command, i_field, i_down, i_value));
        end
        o_pending = due_results.size();
    end

endmodule

// ----- verif/bcd_clock_set_and_alarm_tb.sv -----
// testbench top for bcd_clock_set_and_alarm: clock, reset, item and alarm stimulus, verdict
// depends on bcdrtc_pkg, the block and bcd_clock_set_and_alarm_checker
`timescale 1ns / 1ps

module bcd_clock_set_and_alarm_tb;
    import bcdrtc_pkg::*;

    localparam int unsigned ON_TICKS       = 1000;
    localparam int unsigned NUM_ALARMS     = 8;
    localparam int unsigned ALARM_REGS     = 8;
    localparam int unsigned CLK_PERIOD     = 20;
    localparam int unsigned RESET_CYCLES   = 5;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned TAIL_CYCLES    = 10;
    localparam int unsigned HOLD_CYCLES    = 60;
    localparam int unsigned WATCHDOG_LIMIT = 5000;

    // field code that selects no time register
    localparam logic [FLD_W-1:0] FLD_NONE = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [CMD_W-1:0]     i_command;
    logic [FLD_W-1:0]     i_field;
    logic                 i_down;
    logic [BCD_W-1:0]     i_value;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [BCD_W-1:0]     o_seconds;
    logic [BCD_W-1:0]     o_minutes;
    logic [BCD_W-1:0]     o_hours;
    logic [BCD_W-1:0]     o_day_of_month;
    logic [BCD_W-1:0]     o_month_now;
    logic [BCD_W-1:0]     o_year_low;
    logic [BCD_W-1:0]     o_century_now;
    logic                 o_relay_on;
    logic                 o_alarm_hit;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [ALARM_W-1:0]   i_cfg_data;

    int unsigned          err_count;
    int unsigned          pending;
    int unsigned          items_sent = 0;
    int unsigned          send_idle  = 0;
    int unsigned          recv_idle  = 0;
    int unsigned          quiet_cycles = 0;
    bit                   hold_req = 1'b0;
    logic [ALARM_W-1:0]   alarm_set [ALARM_REGS];

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    bcd_clock_set_and_alarm #(
        .ON_TICKS   (ON_TICKS),
        .NUM_ALARMS (NUM_ALARMS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_field        (i_field),
        .i_down         (i_down),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_seconds      (o_seconds),
        .o_minutes      (o_minutes),
        .o_hours        (o_hours),
        .o_day_of_month (o_day_of_month),
        .o_month_now    (o_month_now),
        .o_year_low     (o_year_low),
        .o_century_now  (o_century_now),
        .o_relay_on     (o_relay_on),
        .o_alarm_hit    (o_alarm_hit),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    bcd_clock_set_and_alarm_checker #(
        .ON_TICKS   (ON_TICKS),
        .NUM_ALARMS (NUM_ALARMS)
    ) i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_field        (i_field),
        .i_down         (i_down),
        .i_value        (i_value),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_seconds      (o_seconds),
        .i_minutes      (o_minutes),
        .i_hours        (o_hours),
        .i_day_of_month (o_day_of_month),
        .i_month_now    (o_month_now),
        .i_year_low     (o_year_low),
        .i_century_now  (o_century_now),
        .i_relay_on     (o_relay_on),
        .i_alarm_hit    (o_alarm_hit),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_err_count    (err_count),
        .o_pending      (pending)
    );

    function automatic logic [FLD_W-1:0] any_fld();
        return FLD_W'($urandom_range(7));
    endfunction

    function automatic logic any_bit();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [BCD_W-1:0] any_byte();
        return BCD_W'($urandom_range(255));
    endfunction

    function automatic logic [BCD_W-1:0] bcd_of(input int unsigned n);
        logic [BCD_W-1:0] r;
        r[7:4] = 4'(n / 10);
        r[3:0] = 4'(n % 10);
        return r;
    endfunction

    // offer one item after a random gap and hold it until it is taken
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [FLD_W-1:0] fld,
                             input logic dn, input logic [BCD_W-1:0] val);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_field    <= fld;
        i_down     <= dn;
        i_value    <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, any_fld(), any_bit(), any_byte());
    endtask

    // load an alarm's hour and minute at second zero (odd_sec: not always), then check
    task automatic alarm_try(input int unsigned idx, input bit odd_sec);
        logic [ALARM_W-1:0] a;
        a = alarm_set[idx];
        send_item(CMD_LOAD, FLD_HOUR, any_bit(), a[15:8]);
        send_item(CMD_LOAD, FLD_MIN, any_bit(), a[7:0]);
        send_item(CMD_LOAD, FLD_SEC, any_bit(),
                  (odd_sec && $urandom_range(9) == 0) ? BCD_W'($urandom_range(1, 255)) : 8'h00);
        send_item(CMD_CHECK, any_fld(), any_bit(), any_byte());
    endtask

    // write every alarm register from alarm_set
    task automatic write_alarms();
        for (int i = 0; i < ALARM_REGS; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_ALARM0 + CFG_IDX_W'(i);
            i_cfg_data  <= alarm_set[i];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic fill_random_alarms();
        int unsigned r;
        for (int i = 0; i < ALARM_REGS; i++) begin
            r = $urandom_range(99);
            if (r < 50)
                alarm_set[i] = {bcd_of($urandom_range(23)), bcd_of($urandom_range(59))};
            else if (r < 75)
                alarm_set[i] = ALARM_W'($urandom);
            else if (r < 90)
                alarm_set[i] = ALARM_OFF;
            else
                alarm_set[i] = '0;
        end
    endtask

    // stop offering items and wait until every readout is back
    task automatic drain();
        i_in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // random mix: alarm sequences, wrap sequences, noise, tick runs, bare checks
    task automatic run_random(input int unsigned count);
        int unsigned      target;
        int unsigned      r;
        int unsigned      n;
        logic [FLD_W-1:0] fld;
        logic [BCD_W-1:0] v;
        target = items_sent + count;
        while (items_sent < target) begin
            r = $urandom_range(99);
            if (r < 30) begin
                alarm_try($urandom_range(ALARM_REGS - 1), 1'b1);
            end else if (r < 55) begin
                fld = any_fld();
                // day wraps depend on month and leap year
                if (fld == FLD_DAY) begin
                    case ($urandom_range(7))
                        0: v = 8'h02;
                        1: v = 8'h04;
                        2: v = 8'h06;
                        3: v = 8'h09;
                        4: v = 8'h11;
                        5: v = 8'h01;
                        6: v = 8'h12;
                        default: v = any_byte();
                    endcase
                    send_item(CMD_LOAD, FLD_MONTH, any_bit(), v);
                    if ($urandom_range(1)) begin
                        case ($urandom_range(2))
                            0: v = 8'h19;
                            1: v = 8'h20;
                            default: v = 8'h21;
                        endcase
                        send_item(CMD_LOAD, FLD_CENT, any_bit(), v);
                        case ($urandom_range(3))
                            0: v = 8'h00;
                            1: v = 8'h24;
                            2: v = 8'h23;
                            default: v = 8'h96;
                        endcase
                        send_item(CMD_LOAD, FLD_YEAR, any_bit(), v);
                    end
                end
                // start value at or near the field's wrap
                case (fld)
                    FLD_SEC, FLD_MIN: begin
                        case ($urandom_range(3))
                            0: v = 8'h00;
                            1: v = 8'h59;
                            2: v = 8'h09;
                            default: v = bcd_of($urandom_range(59));
                        endcase
                    end
                    FLD_HOUR: begin
                        case ($urandom_range(3))
                            0: v = 8'h00;
                            1: v = 8'h23;
                            2: v = 8'h19;
                            default: v = bcd_of($urandom_range(23));
                        endcase
                    end
                    FLD_DAY: begin
                        case ($urandom_range(5))
                            0: v = 8'h01;
                            1: v = 8'h28;
                            2: v = 8'h29;
                            3: v = 8'h30;
                            4: v = 8'h31;
                            default: v = any_byte();
                        endcase
                    end
                    FLD_MONTH: begin
                        case ($urandom_range(3))
                            0: v = 8'h01;
                            1: v = 8'h12;
                            2: v = 8'h09;
                            default: v = any_byte();
                        endcase
                    end
                    FLD_YEAR, FLD_CENT: begin
                        case ($urandom_range(2))
                            0: v = 8'h00;
                            1: v = 8'h99;
                            default: v = any_byte();
                        endcase
                    end
                    default: v = any_byte();
                endcase
                // now and then a code that is not bcd at all
                if ($urandom_range(7) == 0) v = any_byte();
                send_item(CMD_LOAD, fld, any_bit(), v);
                n = $urandom_range(1, 3);
                repeat (n) send_item(CMD_STEP, fld, any_bit(), any_byte());
            end else if (r < 75) begin
                send_item(CMD_W'($urandom_range(3)), any_fld(), any_bit(), any_byte());
            end else if (r < 90) begin
                n = $urandom_range(1, 6);
                repeat (n) send_tick();
            end else begin
                send_item(CMD_CHECK, any_fld(), any_bit(), any_byte());
            end
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    // stimulus and verdict
    initial begin
        int unsigned ticks;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_command   = CMD_LOAD;
        i_field     = FLD_SEC;
        i_down      = 1'b0;
        i_value     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ALARM0;
        i_cfg_data  = '0;
        send_idle   = 32;
        recv_idle   = 58;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // first alarm setting, with both extremes
        alarm_set[0] = 16'h0000;
        alarm_set[1] = 16'h2359;
        alarm_set[2] = 16'h1230;
        for (int i = 3; i < ALARM_REGS - 1; i++)
            alarm_set[i] = {bcd_of($urandom_range(23)), bcd_of($urandom_range(59))};
        alarm_set[ALARM_REGS - 1] = ALARM_OFF;
        write_alarms();

        // alarm 0 is 00:00, so a check right after reset hits
        send_item(CMD_CHECK, FLD_SEC, 1'b0, 8'h00);
        send_item(CMD_TICK, FLD_SEC, 1'b0, 8'h00);
        // seconds wrap both ways
        send_item(CMD_LOAD, FLD_SEC, 1'b0, 8'h59);
        send_item(CMD_STEP, FLD_SEC, 1'b0, 8'h00);
        send_item(CMD_STEP, FLD_SEC, 1'b1, 8'h00);
        // check away from second zero
        send_item(CMD_CHECK, FLD_SEC, 1'b0, 8'h00);
        // hour wrap
        send_item(CMD_LOAD, FLD_HOUR, 1'b0, 8'h23);
        send_item(CMD_STEP, FLD_HOUR, 1'b0, 8'h00);
        send_item(CMD_STEP, FLD_HOUR, 1'b1, 8'h00);
        // month wrap
        send_item(CMD_LOAD, FLD_MONTH, 1'b0, 8'h12);
        send_item(CMD_STEP, FLD_MONTH, 1'b0, 8'h00);
        send_item(CMD_STEP, FLD_MONTH, 1'b1, 8'h00);
        // year carry into and borrow from the century
        send_item(CMD_LOAD, FLD_YEAR, 1'b0, 8'h99);
        send_item(CMD_STEP, FLD_YEAR, 1'b0, 8'h00);
        send_item(CMD_STEP, FLD_YEAR, 1'b1, 8'h00);
        // century wrap
        send_item(CMD_LOAD, FLD_CENT, 1'b0, 8'h99);
        send_item(CMD_STEP, FLD_CENT, 1'b0, 8'h00);
        // leap day of 2000
        send_item(CMD_LOAD, FLD_MONTH, 1'b0, 8'h02);
        send_item(CMD_LOAD, FLD_CENT, 1'b0, 8'h20);
        send_item(CMD_LOAD, FLD_YEAR, 1'b0, 8'h00);
        send_item(CMD_LOAD, FLD_DAY, 1'b0, 8'h29);
        send_item(CMD_STEP, FLD_DAY, 1'b0, 8'h00);
        send_item(CMD_STEP, FLD_DAY, 1'b1, 8'h00);
        // unused field code changes nothing
        send_item(CMD_LOAD, FLD_NONE, 1'b1, 8'hff);
        send_item(CMD_STEP, FLD_NONE, 1'b1, 8'hff);

        run_random(160);

        // second setting, roles of the two sides swapped, one long receiver hold
        drain();
        fill_random_alarms();
        write_alarms();
        send_idle = 58;
        recv_idle = 32;
        run_random(80);
        hold_req = 1'b1;
        run_random(80);

        // third setting, no idling: hit, then run the relay timer out
        drain();
        fill_random_alarms();
        alarm_set[5] = {bcd_of($urandom_range(23)), bcd_of($urandom_range(59))};
        write_alarms();
        send_idle = 0;
        recv_idle = 0;
        alarm_try(5, 1'b0);
        ticks = 0;
        while (ticks < ON_TICKS + 3) begin
            if ($urandom_range(9) == 0) begin
                send_item($urandom_range(1) ? CMD_STEP : CMD_LOAD, any_fld(), any_bit(),
                          any_byte());
            end else begin
                send_tick();
                ticks++;
            end
        end
        run_random(40);

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (err_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
